>>> rtl/core/dtlb_pkg.sv
// Shared constants, command and register codes, and types of the depth-tested line buffer.
package dtlb_pkg;

    localparam int CHANNELS  = 3;
    localparam int MAX_RES   = 256;
    localparam int NREGS     = 3;

    localparam int CMD_W     = 3;
    localparam int CHAN_W    = 2;
    localparam int SLOT_W    = 8;
    localparam int COLOR_W   = 16;
    localparam int DEPTH_W   = 17;
    localparam int POS_W     = 17;
    localparam int RES_W     = 9;

    localparam int MEM_DEPTH = CHANNELS * MAX_RES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int MEM_W     = DEPTH_W + COLOR_W;
    localparam int IDX_W     = $clog2(MAX_RES);
    localparam int PROD_W    = POS_W + RES_W;
    localparam int FRAC_W    = 16;

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [POS_W-1:0]   ONE_Q16  = POS_W'(65536);
    localparam logic [PROD_W-1:0]  HALF_Q16 = PROD_W'(32768);
    localparam logic [DEPTH_W-1:0] FAR_DEPTH = DEPTH_W'(65536);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INTERP = 3'd4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_RES_CHAN0 = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RES_CHAN1 = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RES_CHAN2 = 2'd2;

    typedef logic [NREGS-1:0][RES_W-1:0] res_arr_t;

    // Memory word: depth above color
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] color;
    } mem_word_t;

    localparam mem_word_t CLEAR_WORD = '{depth: FAR_DEPTH, color: '0};

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        mem_word_t         wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

>>> rtl/core/dtlb_if.sv
// Valid/ready channel interfaces for command items and result items.
interface dtlb_in_if;
    logic                          valid;
    logic                          ready;
    logic [dtlb_pkg::CMD_W-1:0]    cmd;
    logic [dtlb_pkg::CHAN_W-1:0]   chan;
    logic [dtlb_pkg::SLOT_W-1:0]   slot;
    logic [dtlb_pkg::COLOR_W-1:0]  sight_in;
    logic [dtlb_pkg::DEPTH_W-1:0]  depth_in;
    logic [dtlb_pkg::POS_W-1:0]    pos_t;

    modport source (output valid, cmd, chan, slot, sight_in, depth_in, pos_t, input ready);
    modport sink   (input valid, cmd, chan, slot, sight_in, depth_in, pos_t, output ready);
endinterface

interface dtlb_out_if;
    logic                          valid;
    logic                          ready;
    logic [dtlb_pkg::COLOR_W-1:0]  sight_out;
    logic                          stored;
    logic                          status;

    modport source (output valid, sight_out, stored, status, input ready);
    modport sink   (input valid, sight_out, stored, status, output ready);
endinterface

>>> rtl/core/dtlb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/dtlb_cfg.sv
// APB register file holding the per-channel resolutions.
module dtlb_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dtlb_pkg::PADDR_W-1:0]  paddr,
    input  logic [dtlb_pkg::PDATA_W-1:0]  pwdata,
    output logic [dtlb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output dtlb_pkg::res_arr_t            res_arr
);
    import dtlb_pkg::*;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_fire;
    res_arr_t             res_reg;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_fire = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign res_arr = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (wr_fire)
        begin
            unique case (reg_idx)
                REG_RES_CHAN0: res_reg[0] <= pwdata[RES_W-1:0];
                REG_RES_CHAN1: res_reg[1] <= pwdata[RES_W-1:0];
                REG_RES_CHAN2: res_reg[2] <= pwdata[RES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RES_CHAN0: prdata = PDATA_W'(res_reg[0]);
            REG_RES_CHAN1: prdata = PDATA_W'(res_reg[1]);
            REG_RES_CHAN2: prdata = PDATA_W'(res_reg[2]);
            default:       prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/dtlb_ctrl.sv
// Command sequencer: clear sweep, read-modify-write, nearest and interpolated reads.
module dtlb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    dtlb_in_if.sink              in_ch,
    dtlb_out_if.source           out_ch,
    input  dtlb_pkg::res_arr_t   res_arr,
    input  dtlb_pkg::mem_word_t  mem_rdata,
    output dtlb_pkg::mem_req_t   mem_req
);
    import dtlb_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_RD0,
        S_RD1,
        S_MUL,
        S_OUT
    } state_t;

    state_t                     state_reg;
    logic [ADDR_W-1:0]          clr_addr_reg;
    logic                       clr_cmd_reg;
    logic [CMD_W-1:0]           cmd_reg;
    logic [CHAN_W-1:0]          chan_reg;
    logic                       chan_ok_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic [COLOR_W-1:0]         sight_reg;
    logic [DEPTH_W-1:0]         depth_reg;
    logic [RES_W-1:0]           rsel_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [ADDR_W-1:0]          addr0_reg;
    logic [ADDR_W-1:0]          addr1_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic [COLOR_W-1:0]         a_reg;
    logic signed [2*COLOR_W+1:0] mul_reg;
    logic [COLOR_W-1:0]         val_reg;
    logic                       st_reg;
    logic                       err_reg;
    logic                       out_valid_reg;
    logic [COLOR_W-1:0]         out_sight_reg;
    logic                       out_stored_reg;
    logic                       out_status_reg;

    logic                       accept;
    logic [POS_W-1:0]           t_clamp;
    logic [RES_W-1:0]           rsel_in;
    logic [PROD_W-1:0]          prod_in;

    logic [RES_W-1:0]           res_m1;
    logic [PROD_W-1:0]          p_sub;
    logic                       p_pos;
    logic [PROD_W-17:0]         near_w;
    logic [PROD_W-17:0]         i0_w;
    logic [PROD_W-17:0]         i0_c;
    logic [PROD_W-17:0]         i1_w;
    logic [PROD_W-17:0]         i1_c;
    logic [IDX_W-1:0]           idx0;
    logic [FRAC_W-1:0]          frac_c;
    logic                       need_rd;
    logic                       err_c;
    logic                       depth_win;
    logic signed [COLOR_W:0]    diff;
    logic signed [2*COLOR_W+1:0] mul_adj;
    logic signed [2*COLOR_W+1:0] mul_sh;
    logic                       out_free;

    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [CHAN_W-1:0] ch,
        input logic [IDX_W-1:0]  idx
    );
        return ADDR_W'(ch) * ADDR_W'(MAX_RES) + ADDR_W'(idx);
    endfunction

    // Input side: clamp position, pick and saturate the channel resolution
    assign accept  = in_ch.valid & in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign t_clamp = (in_ch.pos_t > ONE_Q16) ? ONE_Q16 : in_ch.pos_t;

    always_comb
    begin
        rsel_in = '0;
        for (int i = 0; i < NREGS; i++)
        begin
            if (in_ch.chan == CHAN_W'(i))
            begin
                rsel_in = (res_arr[i] > RES_W'(MAX_RES)) ? RES_W'(MAX_RES) : res_arr[i];
            end
        end
    end

    assign prod_in = PROD_W'(t_clamp) * PROD_W'(rsel_in);

    // Index and fraction from the registered product
    assign res_m1 = rsel_reg - RES_W'(1);
    assign p_pos  = (prod_reg >= HALF_Q16);
    assign p_sub  = prod_reg - HALF_Q16;
    assign near_w = prod_reg[PROD_W-1:16];
    assign i0_w   = p_pos ? p_sub[PROD_W-1:16] : '0;
    assign frac_c = p_pos ? p_sub[FRAC_W-1:0] : '0;
    assign i0_c   = (i0_w > (PROD_W-16)'(res_m1)) ? (PROD_W-16)'(res_m1) : i0_w;
    assign i1_w   = i0_c + (PROD_W-16)'(1);
    assign i1_c   = (i1_w > (PROD_W-16)'(res_m1)) ? (PROD_W-16)'(res_m1) : i1_w;

    always_comb
    begin
        need_rd = 1'b0;
        err_c   = 1'b0;
        idx0    = slot_reg;
        case (cmd_reg) inside
            CMD_WRITE, CMD_READ:
            begin
                err_c   = !chan_ok_reg || ({1'b0, slot_reg} >= rsel_reg);
                need_rd = !err_c;
            end
            CMD_NEAR:
            begin
                err_c   = !chan_ok_reg || (rsel_reg == '0);
                need_rd = !err_c;
                idx0    = (near_w > (PROD_W-16)'(res_m1)) ? res_m1[IDX_W-1:0]
                                                          : near_w[IDX_W-1:0];
            end
            CMD_INTERP:
            begin
                err_c   = !chan_ok_reg;
                need_rd = chan_ok_reg && (rsel_reg != '0);
                idx0    = i0_c[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    assign depth_win = (depth_reg < mem_rdata.depth);
    assign diff      = $signed({1'b0, mem_rdata.color}) - $signed({1'b0, a_reg});
    // Truncate the scaled difference toward zero
    assign mul_adj   = mul_reg + (mul_reg[2*COLOR_W+1] ? (2*COLOR_W+2)'(65535)
                                                       : (2*COLOR_W+2)'(0));
    assign mul_sh    = mul_adj >>> 16;
    assign out_free  = !out_valid_reg || out_ch.ready;

    // Memory requests
    always_comb
    begin
        mem_req = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_addr_reg;
                mem_req.wdata = CLEAR_WORD;
            end
            S_CALC:
            begin
                mem_req.re    = need_rd;
                mem_req.raddr = entry_addr(chan_reg, idx0);
            end
            S_RD0:
            begin
                if (cmd_reg == CMD_WRITE)
                begin
                    mem_req.we    = depth_win;
                    mem_req.waddr = addr0_reg;
                    mem_req.wdata = '{depth: depth_reg, color: sight_reg};
                end
                else if (cmd_reg == CMD_INTERP)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = addr1_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.sight_out = out_sight_reg;
    assign out_ch.stored    = out_stored_reg;
    assign out_ch.status    = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            clr_cmd_reg    <= 1'b0;
            cmd_reg        <= '0;
            chan_reg       <= '0;
            chan_ok_reg    <= 1'b0;
            slot_reg       <= '0;
            sight_reg      <= '0;
            depth_reg      <= '0;
            rsel_reg       <= '0;
            prod_reg       <= '0;
            addr0_reg      <= '0;
            addr1_reg      <= '0;
            frac_reg       <= '0;
            a_reg          <= '0;
            mul_reg        <= '0;
            val_reg        <= '0;
            st_reg         <= 1'b0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_sight_reg  <= '0;
            out_stored_reg <= 1'b0;
            out_status_reg <= 1'b0;
        end
        else
        begin
            // Drop the result once taken, unless a new one loads this cycle
            if (out_valid_reg && out_ch.ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                    begin
                        clr_addr_reg <= '0;
                        val_reg      <= '0;
                        st_reg       <= 1'b0;
                        err_reg      <= 1'b0;
                        state_reg    <= clr_cmd_reg ? S_OUT : S_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg     <= in_ch.cmd;
                        chan_reg    <= in_ch.chan;
                        chan_ok_reg <= (in_ch.chan < CHAN_W'(CHANNELS));
                        slot_reg    <= in_ch.slot;
                        sight_reg   <= in_ch.sight_in;
                        depth_reg   <= in_ch.depth_in;
                        rsel_reg    <= rsel_in;
                        prod_reg    <= prod_in;
                        if (in_ch.cmd == CMD_CLEAR)
                        begin
                            clr_cmd_reg  <= 1'b1;
                            clr_addr_reg <= '0;
                            state_reg    <= S_CLEAR;
                        end
                        else
                        begin
                            state_reg <= S_CALC;
                        end
                    end
                end
                S_CALC:
                begin
                    addr0_reg <= entry_addr(chan_reg, idx0);
                    addr1_reg <= entry_addr(chan_reg, i1_c[IDX_W-1:0]);
                    frac_reg  <= frac_c;
                    val_reg   <= '0;
                    st_reg    <= 1'b0;
                    err_reg   <= err_c;
                    state_reg <= need_rd ? S_RD0 : S_OUT;
                end
                S_RD0:
                begin
                    if (cmd_reg == CMD_WRITE)
                    begin
                        st_reg    <= depth_win;
                        state_reg <= S_OUT;
                    end
                    else if (cmd_reg == CMD_INTERP)
                    begin
                        a_reg     <= mem_rdata.color;
                        state_reg <= S_RD1;
                    end
                    else
                    begin
                        val_reg   <= mem_rdata.color;
                        state_reg <= S_OUT;
                    end
                end
                S_RD1:
                begin
                    mul_reg   <= diff * $signed({1'b0, frac_reg});
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    val_reg   <= a_reg + mul_sh[COLOR_W-1:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // Hold the result until the output register frees up
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sight_reg  <= val_reg;
                        out_stored_reg <= st_reg;
                        out_status_reg <= err_reg;
                        clr_cmd_reg    <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/depth_tested_line_buffer.sv
// Top level of the depth-tested line buffer: registers, sequencer and entry memory.
//
// Usage:
//   in_ch carries one command per transfer (clear, depth-tested write, indexed
//   read, nearest read, interpolated read); out_ch returns exactly one result
//   per command. The APB port sets the per-channel resolutions (res_chan0..2 at
//   byte addresses 0, 4, 8); pready is always high; write only while idle.
//   Color and depth of all channels share one 768 x 33 memory with a
//   registered read port; every command goes through it one item at a time.
//   Write, indexed read and nearest read make one memory read (plus a write
//   back for a winning depth test); commands that read no entry (errors,
//   unknown codes, an interpolated read at resolution 0) make none; an
//   interpolated read makes two reads and one multiply; clear writes one
//   entry per cycle. A new item is taken only after the result is loaded.
//   After reset every entry is swept to color 0, depth 1.0, and in_ch.ready
//   stays low during the sweep. Resolutions reset to 0. If the receiver
//   stalls, the result holds in the output register while the next item is
//   processed; that item then waits until the register frees.
module depth_tested_line_buffer (
    input  logic                          clk,
    input  logic                          rst_n,
    dtlb_in_if.sink                       in_ch,
    dtlb_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dtlb_pkg::PADDR_W-1:0]  paddr,
    input  logic [dtlb_pkg::PDATA_W-1:0]  pwdata,
    output logic [dtlb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import dtlb_pkg::*;

    res_arr_t  res_arr;
    mem_req_t  mem_req;
    mem_word_t mem_rdata;

    dtlb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .res_arr (res_arr)
    );

    dtlb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .res_arr   (res_arr),
        .mem_rdata (mem_rdata),
        .mem_req   (mem_req)
    );

    dtlb_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.we),
        .wr_addr (mem_req.waddr),
        .wr_data (mem_req.wdata),
        .rd_en   (mem_req.re),
        .rd_addr (mem_req.raddr),
        .rd_data (mem_rdata)
    );

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("second item taken while one is in progress");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && in_ch.ready))
        else $error("memory written while accepting input");

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (mem_req.waddr < ADDR_W'(MEM_DEPTH)))
        else $error("memory write beyond last entry");
`endif

endmodule

>>> dv/depth_tested_line_buffer_test.sv
// Self-checking testbench for the depth-tested line buffer: directed table, then random traffic.
module depth_tested_line_buffer_test;
    import dtlb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RESET_CYCLES = 7;
    localparam int RESET_ROWS   = 4;
    localparam int N_DIRECTED   = 26;
    localparam int N_PHASES     = 5;
    localparam int PHASE_ITEMS  = 230;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;

    localparam logic [CMD_W-1:0]  CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_RSVD7 = 3'd7;
    localparam logic [CHAN_W-1:0] BAD_CHAN  = 2'd3;
    localparam logic              STAT_OK   = 1'b0;
    localparam logic              STAT_ERR  = 1'b1;

    localparam logic [REG_IDX_W-1:0] RES_REGS [NREGS] = '{REG_RES_CHAN0, REG_RES_CHAN1,
                                                          REG_RES_CHAN2};

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CHAN_W-1:0]  chan;
        logic [SLOT_W-1:0]  slot;
        logic [COLOR_W-1:0] sight;
        logic [DEPTH_W-1:0] depth;
        logic [POS_W-1:0]   pos;
    } buf_cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] sight;
        logic               stored;
        logic               status;
    } buf_resp_t;

    typedef struct packed {
        buf_cmd_t  c;
        logic      has_exp;
        buf_resp_t r;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    dtlb_in_if  in_ch ();
    dtlb_out_if out_ch ();

    depth_tested_line_buffer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [COLOR_W-1:0] shadow_color [MEM_DEPTH];
    logic [DEPTH_W-1:0] shadow_depth [MEM_DEPTH];
    logic [RES_W-1:0]   shadow_res   [NREGS];
    buf_resp_t          resp_due_q [$];
    dir_row_t           plan [N_DIRECTED];
    int                 fail_count = 0;
    int                 cycle_count = 0;
    bit                 calm_tx = 1'b0;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic note_fail(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    function automatic void wipe_shadow();
        for (int i = 0; i < MEM_DEPTH; i++)
        begin
            shadow_color[i] = '0;
            shadow_depth[i] = FAR_DEPTH;
        end
    endfunction

    // Resolution in effect for a channel: saturate at MAX_RES, none for a bad channel
    function automatic int unsigned used_res(logic [CHAN_W-1:0] chan);
        if (chan >= NREGS)
            return 0;
        return (shadow_res[chan] > MAX_RES) ? MAX_RES : shadow_res[chan];
    endfunction

    function automatic buf_resp_t buffer_response(buf_cmd_t c);
        buf_resp_t   r;
        int unsigned res, base, t, prod, p, i0, i1, f;
        longint      a, b;
        r    = '0;
        res  = used_res(c.chan);
        base = (c.chan < CHANNELS) ? c.chan * MAX_RES : 0;
        t    = (c.pos > ONE_Q16) ? ONE_Q16 : c.pos;
        if (c.cmd == CMD_CLEAR)
            wipe_shadow();
        else if (c.cmd <= CMD_INTERP)
        begin
            if (c.chan >= CHANNELS)
                r.status = STAT_ERR;
            else if (c.cmd == CMD_WRITE || c.cmd == CMD_READ)
            begin
                if (c.slot >= res)
                    r.status = STAT_ERR;
                else if (c.cmd == CMD_READ)
                    r.sight = shadow_color[base + c.slot];
                else if (c.depth < shadow_depth[base + c.slot])
                begin
                    shadow_color[base + c.slot] = c.sight;
                    shadow_depth[base + c.slot] = c.depth;
                    r.stored = 1'b1;
                end
            end
            else if (c.cmd == CMD_NEAR)
            begin
                if (res == 0)
                    r.status = STAT_ERR;
                else
                begin
                    i0 = (t * res) >> 16;
                    if (i0 > res - 1)
                        i0 = res - 1;
                    r.sight = shadow_color[base + i0];
                end
            end
            else if (res == 1)
                r.sight = shadow_color[base];
            else if (res >= 2)
            begin
                prod = t * res;
                i0   = 0;
                f    = 0;
                // below the first half step: entry 0, no blend
                if (prod >= HALF_Q16)
                begin
                    p  = prod - HALF_Q16;
                    i0 = p >> 16;
                    f  = p & 32'hFFFF;
                end
                if (i0 > res - 1)
                    i0 = res - 1;
                i1 = (i0 + 1 > res - 1) ? res - 1 : i0 + 1;
                a  = shadow_color[base + i0];
                b  = shadow_color[base + i1];
                r.sight = COLOR_W'(a + ((b - a) * longint'(f)) / 65536);
            end
        end
        return r;
    endfunction

    function automatic buf_cmd_t random_cmd();
        buf_cmd_t    c;
        int unsigned roll, res;
        roll   = $urandom_range(0, 99);
        c.chan = ($urandom_range(0, 19) == 0) ? BAD_CHAN : CHAN_W'($urandom_range(0, CHANNELS - 1));
        res    = used_res(c.chan);
        if (roll < 2)
            c.cmd = CMD_CLEAR;
        else if (roll < 5)
            c.cmd = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
        else if (roll < 40)
            c.cmd = CMD_WRITE;
        else if (roll < 55)
            c.cmd = CMD_READ;
        else if (roll < 70)
            c.cmd = CMD_NEAR;
        else
            c.cmd = CMD_INTERP;
        // keep most slots in range so writes and reads reach the store
        if (res != 0 && $urandom_range(0, 9) != 0)
            c.slot = SLOT_W'($urandom_range(0, res - 1));
        else
            c.slot = SLOT_W'($urandom);
        c.sight = COLOR_W'($urandom);
        case ($urandom_range(0, 3))
            0:       c.depth = DEPTH_W'($urandom);
            1:       c.depth = DEPTH_W'($urandom_range(0, 65536));
            2:       c.depth = DEPTH_W'($urandom_range(0, 4095));
            default: c.depth = $urandom_range(0, 1) ? FAR_DEPTH : '0;
        endcase
        if ($urandom_range(0, 7) == 0)
            c.pos = POS_W'($urandom_range(65537, 131071));
        else
            c.pos = POS_W'($urandom_range(0, 65536));
        return c;
    endfunction

    function automatic dir_row_t plan_row(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] chan,
                                          logic [SLOT_W-1:0] slot, logic [COLOR_W-1:0] sight,
                                          logic [DEPTH_W-1:0] depth, logic [POS_W-1:0] pos,
                                          logic has_exp, logic [COLOR_W-1:0] want_sight,
                                          logic want_stored, logic want_status);
        dir_row_t r;
        r.c.cmd    = cmd;
        r.c.chan   = chan;
        r.c.slot   = slot;
        r.c.sight  = sight;
        r.c.depth  = depth;
        r.c.pos    = pos;
        r.has_exp  = has_exp;
        r.r.sight  = want_sight;
        r.r.stored = want_stored;
        r.r.status = want_status;
        return r;
    endfunction

    task automatic send_cmd(buf_cmd_t c, logic has_exp, buf_resp_t want);
        int unsigned gap;
        buf_resp_t   r;
        gap = calm_tx ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.cmd      <= c.cmd;
        in_ch.chan     <= c.chan;
        in_ch.slot     <= c.slot;
        in_ch.sight_in <= c.sight;
        in_ch.depth_in <= c.depth;
        in_ch.pos_t    <= c.pos;
        do @(posedge clk); while (!in_ch.ready);
        r = buffer_response(c);
        resp_due_q.push_back(has_exp ? want : r);
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic await_idle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (resp_due_q.size() != 0);
    endtask

    task automatic program_res(logic [RES_W-1:0] r0, logic [RES_W-1:0] r1, logic [RES_W-1:0] r2);
        logic [RES_W-1:0]   vals [NREGS];
        logic [PDATA_W-1:0] data;
        vals = '{r0, r1, r2};
        for (int i = 0; i < NREGS; i++)
        begin
            // junk above the register width must be dropped
            data = ($urandom << RES_W) | PDATA_W'(vals[i]);
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= PADDR_W'({RES_REGS[i], 2'b00});
            pwdata  <= data;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            shadow_res[RES_REGS[i]] = vals[i];
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (prdata !== PDATA_W'(vals[i]))
                note_fail($sformatf("res register %0d readback: expected %h, got %h",
                                    i, PDATA_W'(vals[i]), prdata));
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    initial
    begin
        buf_resp_t   got;
        buf_resp_t   want;
        int unsigned stall;
        int unsigned seen;
        bit          calm_rx;
        out_ch.ready = 1'b0;
        seen         = 0;
        calm_rx      = 1'b0;
        forever
        begin
            if (seen % 32 == 0)
                calm_rx = ($urandom_range(0, 3) == 0);
            stall = calm_rx ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got.sight  = out_ch.sight_out;
            got.stored = out_ch.stored;
            got.status = out_ch.status;
            if (resp_due_q.size() == 0)
                note_fail($sformatf("result %0d with none expected: sight=%h stored=%b status=%b",
                                    seen, got.sight, got.stored, got.status));
            else
            begin
                want = resp_due_q.pop_front();
                if (got.sight !== want.sight)
                    note_fail($sformatf("result %0d sight_out: expected %h, got %h",
                                        seen, want.sight, got.sight));
                if (got.stored !== want.stored)
                    note_fail($sformatf("result %0d stored: expected %b, got %b",
                                        seen, want.stored, got.stored));
                if (got.status !== want.status)
                    note_fail($sformatf("result %0d status: expected %b, got %b",
                                        seen, want.status, got.status));
            end
            seen++;
        end
    end

    initial
    begin
        in_ch.valid    = 1'b0;
        in_ch.cmd      = CMD_CLEAR;
        in_ch.chan     = '0;
        in_ch.slot     = '0;
        in_ch.sight_in = '0;
        in_ch.depth_in = '0;
        in_ch.pos_t    = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        for (int i = 0; i < NREGS; i++)
            shadow_res[i] = '0;
        wipe_shadow();

        // resolutions still at reset: everything reads as empty or out of range
        plan[0]  = plan_row(CMD_INTERP, 2'd0, 8'd0, 16'h0, 17'd0, 17'd32768, 1'b1, 16'h0, 1'b0, STAT_OK);
        plan[1]  = plan_row(CMD_NEAR, 2'd0, 8'd0, 16'h0, 17'd0, 17'd65536, 1'b1, 16'h0, 1'b0, STAT_ERR);
        plan[2]  = plan_row(CMD_WRITE, 2'd1, 8'd0, 16'h5555, 17'd10, 17'd0, 1'b1, 16'h0, 1'b0, STAT_ERR);
        plan[3]  = plan_row(CMD_WRITE, BAD_CHAN, 8'd0, 16'h5555, 17'd10, 17'd0, 1'b1, 16'h0, 1'b0,
                            STAT_ERR);
        // resolutions 511 (saturates to 256), 1 and 2
        plan[4]  = plan_row(CMD_READ, 2'd0, 8'd255, 16'h0, 17'd0, 17'd0, 1'b1, 16'h0, 1'b0, STAT_OK);
        plan[5]  = plan_row(CMD_WRITE, 2'd0, 8'd255, 16'hFFFF, 17'd0, 17'd0, 1'b1, 16'h0, 1'b1, STAT_OK);
        plan[6]  = plan_row(CMD_WRITE, 2'd0, 8'd255, 16'h1234, 17'd0, 17'd0, 1'b1, 16'h0, 1'b0, STAT_OK);
        plan[7]  = plan_row(CMD_READ, 2'd0, 8'd255, 16'h0, 17'd0, 17'd0, 1'b1, 16'hFFFF, 1'b0, STAT_OK);
        plan[8]  = plan_row(CMD_WRITE, 2'd0, 8'd0, 16'h8000, 17'd65536, 17'd0, 1'b1, 16'h0, 1'b0,
                            STAT_OK);
        plan[9]  = plan_row(CMD_WRITE, 2'd0, 8'd0, 16'h8000, 17'd65535, 17'd0, 1'b1, 16'h0, 1'b1,
                            STAT_OK);
        plan[10] = plan_row(CMD_WRITE, 2'd0, 8'd0, 16'h7000, 17'd131071, 17'd0, 1'b1, 16'h0, 1'b0,
                            STAT_OK);
        plan[11] = plan_row(CMD_NEAR, 2'd0, 8'd0, 16'h0, 17'd0, 17'd0, 1'b1, 16'h8000, 1'b0, STAT_OK);
        plan[12] = plan_row(CMD_NEAR, 2'd0, 8'd0, 16'h0, 17'd0, 17'd131071, 1'b1, 16'hFFFF, 1'b0,
                            STAT_OK);
        plan[13] = plan_row(CMD_INTERP, 2'd0, 8'd0, 16'h0, 17'd0, 17'd0, 1'b1, 16'h8000, 1'b0, STAT_OK);
        plan[14] = plan_row(CMD_INTERP, 2'd0, 8'd0, 16'h0, 17'd0, 17'd65536, 1'b1, 16'hFFFF, 1'b0,
                            STAT_OK);
        plan[15] = plan_row(CMD_INTERP, 2'd0, 8'd0, 16'h0, 17'd0, 17'd100, 1'b0, 16'h0, 1'b0, STAT_OK);
        plan[16] = plan_row(CMD_WRITE, 2'd1, 8'd0, 16'hABCD, 17'd100, 17'd0, 1'b1, 16'h0, 1'b1,
                            STAT_OK);
        plan[17] = plan_row(CMD_WRITE, 2'd1, 8'd1, 16'hABCD, 17'd100, 17'd0, 1'b1, 16'h0, 1'b0,
                            STAT_ERR);
        plan[18] = plan_row(CMD_INTERP, 2'd1, 8'd0, 16'h0, 17'd0, 17'd40000, 1'b1, 16'hABCD, 1'b0,
                            STAT_OK);
        plan[19] = plan_row(CMD_WRITE, 2'd2, 8'd0, 16'hF000, 17'd7, 17'd0, 1'b1, 16'h0, 1'b1, STAT_OK);
        plan[20] = plan_row(CMD_WRITE, 2'd2, 8'd1, 16'h00FF, 17'd5, 17'd0, 1'b1, 16'h0, 1'b1, STAT_OK);
        plan[21] = plan_row(CMD_INTERP, 2'd2, 8'd0, 16'h0, 17'd0, 17'd40000, 1'b0, 16'h0, 1'b0, STAT_OK);
        plan[22] = plan_row(CMD_RSVD5, 2'd1, 8'd0, 16'h0, 17'd0, 17'd0, 1'b1, 16'h0, 1'b0, STAT_OK);
        plan[23] = plan_row(CMD_RSVD7, BAD_CHAN, 8'd0, 16'h0, 17'd0, 17'd0, 1'b1, 16'h0, 1'b0, STAT_OK);
        plan[24] = plan_row(CMD_CLEAR, BAD_CHAN, 8'd0, 16'h0, 17'd0, 17'd0, 1'b1, 16'h0, 1'b0, STAT_OK);
        plan[25] = plan_row(CMD_READ, 2'd0, 8'd255, 16'h0, 17'd0, 17'd0, 1'b1, 16'h0, 1'b0, STAT_OK);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        // wait out the clearing sweep after reset
        do @(posedge clk); while (!in_ch.ready);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (i == RESET_ROWS)
            begin
                await_idle();
                program_res(9'd511, 9'd1, 9'd2);
            end
            send_cmd(plan[i].c, plan[i].has_exp, plan[i].r);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            await_idle();
            case (ph)
                0:       program_res(9'd256, 9'd2, 9'd257);
                1:       program_res(9'd0, 9'd255, 9'd128);
                2:       program_res(9'd1, 9'd0, 9'd256);
                default: program_res(RES_W'($urandom), RES_W'($urandom), RES_W'($urandom));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    await_idle();
                if (n % 40 == 0)
                    calm_tx = ($urandom_range(0, 3) == 0);
                send_cmd(random_cmd(), 1'b0, '0);
            end
        end

        await_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && resp_due_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
